// ----- hdl/utf8_decode_validate_top_assert.svh -----
// Assertion macros for the decoder file.
// Each use expects clk and rst_n in scope.
`ifndef UTF8_DECODE_VALIDATE_TOP_ASSERT_SVH
`define UTF8_DECODE_VALIDATE_TOP_ASSERT_SVH

// Same-cycle implication.
`define UDV_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("utf8 decoder check failed");

// Next-cycle implication.
`define UDV_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("utf8 decoder check failed");

`endif

// ----- hdl/utf8dv_pkg.sv -----
`default_nettype none
package utf8dv_pkg;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_EF     = 8'hEF;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] CONT_BF     = 8'hBF;
  localparam logic [7:0] CONT_8F     = 8'h8F;
  localparam logic [6:0] LEAD_C0_C1  = 7'h60;  // C0 or C1 in the upper 7 bits
  localparam logic [6:0] CONT_BE_BF  = 7'h5F;  // BE or BF in the upper 7 bits

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        malformed;
    logic        at_end;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/utf8dv_in_reg.sv -----
`default_nettype none
module utf8dv_in_reg
  import utf8dv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,   // downstream takes the held word this cycle
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/utf8dv_dec.sv -----
`default_nettype none
module utf8dv_dec
  import utf8dv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_item_t item,
  output logic          res_valid,
  output result_t       res
);

  logic [1:0]  pending_r,   pending_nxt;
  logic [2:0]  seq_len_r,   seq_len_nxt;
  logic [7:0]  lead_r,      lead_nxt;
  logic [20:0] partial_r,   partial_nxt;
  logic        second_bf_r, second_bf_nxt;

  logic [7:0]  b;
  logic        fin;
  logic [2:0]  pos;
  logic [1:0]  pend_dec;
  logic [20:0] partial_sh;
  logic        cont_fault;
  logic        emit_ok;
  logic        emit_bad;

  assign b          = item.data_byte;
  assign fin        = item.final_byte;
  assign pos        = seq_len_r - {1'b0, pending_r};
  assign pend_dec   = pending_r - 2'd1;
  assign partial_sh = {partial_r[14:0], b[5:0]};

  // Range checks tied to the lead byte; second byte and the EF BF BE/BF case.
  always_comb begin
    cont_fault = 1'b0;
    if (pos == 3'd1) begin
      if ((lead_r == LEAD_E0 && b[7:5] == 3'b100) ||
          (lead_r == LEAD_ED && b[7:5] == 3'b101) ||
          (lead_r == LEAD_F0 && b[7:4] == 4'b1000) ||
          (lead_r == LEAD_F4 && b > CONT_8F)) begin
        cont_fault = 1'b1;
      end
    end else if (pos == 3'd2 && seq_len_r == 3'd3) begin
      if (lead_r == LEAD_EF && second_bf_r && b[7:1] == CONT_BE_BF) begin
        cont_fault = 1'b1;
      end
    end
  end

  always_comb begin
    pending_nxt   = pending_r;
    seq_len_nxt   = seq_len_r;
    lead_nxt      = lead_r;
    partial_nxt   = partial_r;
    second_bf_nxt = second_bf_r;
    emit_ok       = 1'b0;
    emit_bad      = 1'b0;
    res           = '0;
    res.at_end    = fin;

    if (step) begin
      if (pending_r == 2'd0) begin
        if (b < ASCII_LIMIT) begin
          emit_ok        = 1'b1;
          res.code_point = {13'd0, b};
          res.byte_count = 3'd1;
        end else if (b[7:5] == 3'b110) begin
          if (b[7:1] == LEAD_C0_C1 || fin) begin
            emit_bad = 1'b1;
          end else begin
            pending_nxt = 2'd1;
            seq_len_nxt = 3'd2;
            partial_nxt = {16'd0, b[4:0]};
          end
        end else if (b[7:4] == 4'b1110) begin
          if (fin) begin
            emit_bad = 1'b1;
          end else begin
            pending_nxt = 2'd2;
            seq_len_nxt = 3'd3;
            partial_nxt = {17'd0, b[3:0]};
          end
        end else if (b[7:3] == 5'b11110) begin
          if (b > LEAD_F4 || fin) begin
            emit_bad = 1'b1;
          end else begin
            pending_nxt = 2'd3;
            seq_len_nxt = 3'd4;
            partial_nxt = {18'd0, b[2:0]};
          end
        end else begin
          emit_bad = 1'b1;
        end
        lead_nxt      = b;
        second_bf_nxt = 1'b0;
      end else begin
        if (b[7:6] != 2'b10 || cont_fault) begin
          emit_bad = 1'b1;
        end else if (pend_dec == 2'd0) begin
          emit_ok        = 1'b1;
          res.code_point = partial_sh;
          res.byte_count = seq_len_r;
        end else if (fin) begin
          emit_bad = 1'b1;
        end else begin
          pending_nxt = pend_dec;
          partial_nxt = partial_sh;
          if (pos == 3'd1) begin
            second_bf_nxt = (b == CONT_BF);
          end
        end
      end

      if (emit_ok || emit_bad) begin
        pending_nxt   = 2'd0;
        seq_len_nxt   = 3'd0;
        lead_nxt      = 8'd0;
        partial_nxt   = 21'd0;
        second_bf_nxt = 1'b0;
      end
    end

    res.malformed = emit_bad;
    res_valid     = emit_ok || emit_bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 2'd0;
      seq_len_r   <= 3'd0;
      lead_r      <= 8'd0;
      partial_r   <= 21'd0;
      second_bf_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      seq_len_r   <= seq_len_nxt;
      lead_r      <= lead_nxt;
      partial_r   <= partial_nxt;
      second_bf_r <= second_bf_nxt;
    end
  end

`include "utf8_decode_validate_top_assert.svh"

  `UDV_ASSERT_NOW(a_bad_is_zero, res_valid && res.malformed, res.code_point == 21'd0 && res.byte_count == 3'd0)
  `UDV_ASSERT_NOW(a_good_len, res_valid && !res.malformed, res.byte_count != 3'd0 && res.byte_count <= 3'd4)
  `UDV_ASSERT_NEXT(a_final_idle, step && fin, pending_r == 2'd0)
  `UDV_ASSERT_NOW(a_open_len, pending_r != 2'd0, seq_len_r > {1'b0, pending_r})

endmodule
`default_nettype wire

// ----- hdl/utf8dv_out_reg.sv -----
`default_nettype none
module utf8dv_out_reg
  import utf8dv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         can_take,   // register is free or drains this cycle
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign valid_nxt = can_take ? res_valid : valid_r;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/utf8_decode_validate_top.sv -----
// Channel | Direction | tdata                               | tuser     | tlast
// in_     | slave     | [7:0] data_byte                     | -         | final_byte
// out_    | master    | [20:0] code_point, [23:21] byte_count | malformed | at_end
//
// One byte per cycle sustained while out_tready stays high.
// A byte is held in the input register, decoded combinationally against the sequence
// state, and its result (if any) lands in the output register.
// rst_n (synchronous) empties both registers and returns the decoder to idle.
// A stalled result word holds the pipe; in_tready drops only when both stages are full.
`default_nettype none
module utf8_decode_validate_top
  import utf8dv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // final_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [20:0] code_point, [23:21] byte_count
  output logic             out_tuser,  // malformed
  output logic             out_tlast   // at_end
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte  = in_tdata;
  assign in_item.final_byte = in_tlast;

  utf8dv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  utf8dv_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (item_valid && advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8dv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.byte_count, out_res.code_point};
  assign out_tuser = out_res.malformed;
  assign out_tlast = out_res.at_end;

endmodule
`default_nettype wire

// ----- test/utf8_decode_validate_top_test.sv -----
module utf8_decode_validate_top_test;
  import utf8dv_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  utf8_decode_validate_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),   // final_byte
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [20:0] code_point, [23:21] byte_count
    .out_tuser  (out_tuser),  // malformed
    .out_tlast  (out_tlast)   // at_end
  );

  always #10 clk = ~clk;

  // decoder state as seen by the predictor
  logic [1:0]  cont_left = '0;
  logic [2:0]  char_len = '0;
  logic [7:0]  lead_seen = '0;
  logic [20:0] value_acc = '0;
  logic        second_bf = 1'b0;

  result_t     expected_chars[$];
  result_t     want;
  int          error_count = 0;
  int          bytes_sent = 0;
  int          send_idle_pct = 29;
  int          recv_stall_pct = 29;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 100) $display("mismatch: %s", what);
  endtask

  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    result_t     r;
    logic        fault;
    logic        done;
    logic [2:0]  pos;
    r = '0;
    fault = 1'b0;
    done = 1'b0;
    if (cont_left == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        r.code_point = {13'd0, b};
        r.byte_count = 3'd1;
        done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        if (b[7:1] == LEAD_C0_C1 || fin) fault = 1'b1;
        else begin
          cont_left = 2'd1;
          char_len = 3'd2;
          value_acc = {16'd0, b[4:0]};
        end
      end else if (b[7:4] == 4'b1110) begin
        if (fin) fault = 1'b1;
        else begin
          cont_left = 2'd2;
          char_len = 3'd3;
          value_acc = {17'd0, b[3:0]};
        end
      end else if (b[7:3] == 5'b11110) begin
        if (b > LEAD_F4 || fin) fault = 1'b1;
        else begin
          cont_left = 2'd3;
          char_len = 3'd4;
          value_acc = {18'd0, b[2:0]};
        end
      end else begin
        fault = 1'b1;
      end
      if (!fault && !done) begin
        lead_seen = b;
        second_bf = 1'b0;
      end
    end else if (b[7:6] != 2'b10) begin
      fault = 1'b1;
    end else begin
      pos = char_len - {1'b0, cont_left};
      if (pos == 3'd1) begin
        // overlong, surrogate and above-range forms show at the second word
        if ((lead_seen == LEAD_E0 && b[7:5] == 3'b100) ||
            (lead_seen == LEAD_ED && b[7:5] == 3'b101) ||
            (lead_seen == LEAD_F0 && b[7:4] == 4'b1000) ||
            (lead_seen == LEAD_F4 && b > CONT_8F))
          fault = 1'b1;
        else
          second_bf = (b == CONT_BF);
      end else if (pos == 3'd2 && char_len == 3'd3) begin
        if (lead_seen == LEAD_EF && second_bf && b[7:1] == CONT_BE_BF) fault = 1'b1;
      end
      if (!fault) begin
        value_acc = {value_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          r.code_point = value_acc;
          r.byte_count = char_len;
          done = 1'b1;
        end else if (fin) begin
          fault = 1'b1;
        end
      end
    end
    if (fault || done) begin
      if (fault) begin
        r = '0;
        r.malformed = 1'b1;
      end
      r.at_end = fin;
      expected_chars.push_back(r);
      cont_left = '0;
      char_len = '0;
      lead_seen = '0;
      value_acc = '0;
      second_bf = 1'b0;
    end
  endfunction

  // valid stays high between back-to-back words; it only drops while idling
  task automatic send_word(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, fin);
    bytes_sent++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected word cp=%h cnt=%0d bad=%b end=%b",
                                  out_tdata[20:0], out_tdata[23:21], out_tuser, out_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[20:0] !== want.code_point)
          report_mismatch($sformatf("code_point %h, want %h",
                                    out_tdata[20:0], want.code_point));
        if (out_tdata[23:21] !== want.byte_count)
          report_mismatch($sformatf("byte_count %0d, want %0d",
                                    out_tdata[23:21], want.byte_count));
        if (out_tuser !== want.malformed)
          report_mismatch($sformatf("malformed %b, want %b", out_tuser, want.malformed));
        if (out_tlast !== want.at_end)
          report_mismatch($sformatf("at_end %b, want %b", out_tlast, want.at_end));
      end
    end
  end

  task automatic test_single_bytes;
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b1);
  endtask

  task automatic test_multi_byte;
    send_word(8'hC2, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'hE0, 1'b0); send_word(8'hA0, 1'b0); send_word(8'h80, 1'b0);
    send_word(8'hF4, 1'b0); send_word(8'h8F, 1'b0); send_word(8'hBF, 1'b0);
    send_word(8'hBF, 1'b1);
  endtask

  task automatic test_bad_leads;
    send_word(8'hC0, 1'b0);
    send_word(8'hC1, 1'b0);
    send_word(8'hF5, 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h80, 1'b0);
  endtask

  task automatic test_sequence_faults;
    // the non-continuation word is dropped along with the open sequence
    send_word(8'hE2, 1'b0); send_word(8'h41, 1'b0);
    send_word(8'hE0, 1'b0); send_word(8'h9F, 1'b0);
    send_word(8'hF0, 1'b0); send_word(8'h8F, 1'b0);
    send_word(8'hED, 1'b0); send_word(8'hA0, 1'b0);
    send_word(8'hF4, 1'b0); send_word(8'h90, 1'b0);
    send_word(8'hEF, 1'b0); send_word(8'hBF, 1'b0); send_word(8'hBE, 1'b0);
  endtask

  task automatic test_truncation;
    send_word(8'hE2, 1'b0); send_word(8'h82, 1'b1);
    send_word(8'hC2, 1'b1);
  endtask

  task automatic test_random;
    int unsigned edge_cps [13] = '{'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hD800, 'hDFFF,
                                   'hE000, 'hFFFD, 'hFFFE, 'hFFFF, 'h10000, 'h10FFFF};
    logic [7:0]  seq [4];
    logic [20:0] cp;
    logic        fin_last;
    int          start;
    int          kind;
    int          n;
    int          cut;
    int          bad;
    start = bytes_sent;
    while (bytes_sent < start + 600) begin
      // a stretch in the middle runs with no idling on either side
      if (bytes_sent >= start + 200 && bytes_sent < start + 400) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct = 29;
        recv_stall_pct = 29;
      end
      kind = $urandom_range(99);
      if (kind < 15) begin
        send_word(8'($urandom_range(255)), $urandom_range(19) == 0);
      end else begin
        if ($urandom_range(9) == 0) cp = 21'(edge_cps[$urandom_range(12)]);
        else begin
          case ($urandom_range(3))
            0: cp = 21'($urandom_range('h7F));
            1: cp = 21'($urandom_range('h7FF, 'h80));
            2: cp = 21'($urandom_range('hFFFF, 'h800));
            default: cp = 21'($urandom_range('h10FFFF, 'h10000));
          endcase
        end
        if (cp < 'h80) begin
          n = 1;
          seq[0] = cp[7:0];
        end else if (cp < 'h800) begin
          n = 2;
          seq[0] = {3'b110, cp[10:6]};
          seq[1] = {2'b10, cp[5:0]};
        end else if (cp < 'h10000) begin
          n = 3;
          seq[0] = {4'b1110, cp[15:12]};
          seq[1] = {2'b10, cp[11:6]};
          seq[2] = {2'b10, cp[5:0]};
        end else begin
          n = 4;
          seq[0] = {5'b11110, cp[20:18]};
          seq[1] = {2'b10, cp[17:12]};
          seq[2] = {2'b10, cp[11:6]};
          seq[3] = {2'b10, cp[5:0]};
        end
        cut = n;
        if (kind >= 85 && n > 1) begin
          if ($urandom_range(1)) cut = $urandom_range(n - 1, 1);
          else begin
            bad = $urandom_range(n - 1, 1);
            seq[bad] = $urandom_range(1) ? 8'($urandom_range('h7F))
                                         : 8'($urandom_range('hFF, 'hC0));
          end
        end
        fin_last = ($urandom_range(9) == 0);
        for (int i = 0; i < cut; i++) send_word(seq[i], (i == cut - 1) && fin_last);
      end
    end
    send_idle_pct = 29;
    recv_stall_pct = 29;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bytes;
    test_multi_byte;
    test_bad_leads;
    test_sequence_faults;
    test_truncation;
    test_random;
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/utf8dv_pkg.sv
hdl/utf8dv_in_reg.sv
hdl/utf8dv_dec.sv
hdl/utf8dv_out_reg.sv
hdl/utf8_decode_validate_top.sv
test/utf8_decode_validate_top_test.sv
